// ===== design/ntci_pkg.sv =====
// Shared types, constants and the NTC calibration table for the table interpolation unit.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package ntci_pkg;

  localparam int AdcW        = 10;
  localparam int TempW       = 7;
  localparam int FlagW       = 2;
  localparam int NumW        = 13;  // holds 5 * (reading - lower point)
  localparam int QuotW       = 3;   // quotient never exceeds 5
  localparam int TableSlots  = 32;
  localparam int IdxW        = $clog2(TableSlots);
  localparam int TablePoints = 13;
  localparam int BaseTemp    = -20;
  localparam int StepTemp    = 5;
  localparam int QueueDepth  = 2;

  typedef logic [AdcW-1:0]  adc_t;
  typedef logic [TempW-1:0] temp_t;

  typedef enum logic [FlagW-1:0] {
    RANGE_IN   = 2'd0,
    RANGE_LOW  = 2'd1,
    RANGE_HIGH = 2'd2
  } range_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DIV  = 1'b1
  } back_state_t;

  // One classified reading waiting for the divider.
  typedef struct packed {
    range_t            flag;
    temp_t             base;
    logic [NumW-1:0]   num;
    adc_t              den;
  } job_t;

  // Converter values at -20 C, -15 C, ... ; unused slots hold full scale.
  localparam adc_t PointTable [TableSlots] = '{
    10'd75,   10'd100,  10'd131,  10'd169,  10'd214,  10'd265,  10'd322,  10'd384,
    10'd447,  10'd512,  10'd574,  10'd633,  10'd687,  10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023
  };

endpackage

`default_nettype wire

// ===== design/ntci_front.sv =====
// Front end: takes a reading, finds its table segment and builds the division job.
// Depends on ntci_pkg for the calibration table and the job type.
`default_nettype none

module ntci_front #(
  parameter int TABLE_POINTS = ntci_pkg::TablePoints
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire ntci_pkg::adc_t in_adc_reading,
  input  wire logic          q_full,
  output logic               q_push,
  output ntci_pkg::job_t     q_job
);

  localparam int Np = (TABLE_POINTS < 2) ? 2 :
                      ((TABLE_POINTS > ntci_pkg::TableSlots) ? ntci_pkg::TableSlots
                                                              : TABLE_POINTS);
  localparam int TopTemp = ntci_pkg::BaseTemp + ntci_pkg::StepTemp * (Np - 1);
  localparam ntci_pkg::temp_t BaseTempW = ntci_pkg::TempW'(ntci_pkg::BaseTemp);
  localparam ntci_pkg::temp_t TopTempW  = ntci_pkg::TempW'(TopTemp);
  localparam ntci_pkg::adc_t  FirstPt   = ntci_pkg::PointTable[0];
  localparam ntci_pkg::adc_t  LastPt    = ntci_pkg::PointTable[Np-1];

  ntci_pkg::adc_t             val_r, val_nxt;
  logic                       valid_r, valid_nxt;
  logic                       accept;
  logic [ntci_pkg::IdxW-1:0]  idx;
  logic [ntci_pkg::IdxW-1:0]  seg;
  logic [ntci_pkg::IdxW+2:0]  seg5;
  ntci_pkg::adc_t             lo, hi, diff;

  assign busy   = valid_r & q_full;
  assign accept = start & ~busy;
  assign q_push = valid_r & ~q_full;

  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = val_r;
    if (accept) begin
      valid_nxt = 1'b1;
      val_nxt   = in_adc_reading;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    val_r <= val_nxt;
  end

  // First point not below the reading; a reading on the first point uses segment one.
  always_comb begin
    idx = ntci_pkg::IdxW'(Np - 1);
    for (int k = Np - 1; k >= 0; k--) begin
      if (val_r <= ntci_pkg::PointTable[k]) idx = ntci_pkg::IdxW'(k);
    end
    if (idx == '0) idx = ntci_pkg::IdxW'(1);
  end

  always_comb begin
    seg  = idx - ntci_pkg::IdxW'(1);
    seg5 = {1'b0, seg, 2'b00} + (ntci_pkg::IdxW+3)'(seg);
    lo   = ntci_pkg::PointTable[seg];
    hi   = ntci_pkg::PointTable[idx];
    diff = val_r - lo;
    q_job.flag = ntci_pkg::RANGE_IN;
    q_job.base = BaseTempW + seg5[ntci_pkg::TempW-1:0];
    q_job.num  = {1'b0, diff, 2'b00} + ntci_pkg::NumW'(diff);
    q_job.den  = hi - lo;
    if (val_r < FirstPt) begin
      q_job.flag = ntci_pkg::RANGE_LOW;
      q_job.base = BaseTempW;
    end else if (val_r > LastPt) begin
      q_job.flag = ntci_pkg::RANGE_HIGH;
      q_job.base = TopTempW;
    end
    // Clamped readings and an empty segment divide zero by one.
    if (q_job.flag != ntci_pkg::RANGE_IN || q_job.den == '0) begin
      q_job.num = '0;
      q_job.den = ntci_pkg::AdcW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== design/ntci_fifo.sv =====
// Short job queue between the front end and the divider.
// Depends on ntci_pkg for the job type and the queue depth.
`default_nettype none

module ntci_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ntci_pkg::job_t wr_data,
  input  wire logic           pop,
  output ntci_pkg::job_t      rd_data,
  output logic                full,
  output logic                empty
);

  localparam int PtrW = $clog2(ntci_pkg::QueueDepth);
  localparam int CntW = $clog2(ntci_pkg::QueueDepth + 1);

  ntci_pkg::job_t    mem_r [ntci_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  assign full    = (count_r == CntW'(ntci_pkg::QueueDepth));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(ntci_pkg::QueueDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(ntci_pkg::QueueDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) count_nxt = count_r + CntW'(1);
    else if (pop && !push) count_nxt = count_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

// ===== design/ntci_back.sv =====
// Back end: restoring divider that finishes the interpolation and drives the result.
// Depends on ntci_pkg for the job type, the state enum and field widths.
`default_nettype none

module ntci_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire ntci_pkg::job_t q_job,
  output logic                q_pop,
  output logic                out_valid,
  output logic signed [ntci_pkg::TempW-1:0] out_temperature_c,
  output logic [ntci_pkg::FlagW-1:0]        out_range_flag
);

  localparam int CntW = $clog2(ntci_pkg::QuotW);

  ntci_pkg::back_state_t       state_r, state_nxt;
  logic [ntci_pkg::NumW-1:0]   rem_r, rem_nxt;
  ntci_pkg::adc_t              den_r, den_nxt;
  ntci_pkg::temp_t             base_r, base_nxt;
  ntci_pkg::range_t            flag_r, flag_nxt;
  logic [CntW-1:0]             cnt_r, cnt_nxt;
  logic [ntci_pkg::QuotW-1:0]  quot_r, quot_nxt;
  logic                        valid_r, valid_nxt;
  ntci_pkg::temp_t             temp_r, temp_nxt;
  logic [ntci_pkg::FlagW-1:0]  oflag_r, oflag_nxt;
  logic [ntci_pkg::NumW-1:0]   trial;
  logic                        fits;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ntci_pkg::BK_IDLE: if (!q_empty) state_nxt = ntci_pkg::BK_DIV;
      ntci_pkg::BK_DIV:  if (cnt_r == '0) state_nxt = ntci_pkg::BK_IDLE;
      default:           state_nxt = ntci_pkg::BK_IDLE;
    endcase
  end

  // One quotient bit per cycle, most significant first.
  assign trial = ntci_pkg::NumW'(den_r) << cnt_r;
  assign fits  = (rem_r >= trial);

  always_comb begin
    q_pop     = 1'b0;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    base_nxt  = base_r;
    flag_nxt  = flag_r;
    cnt_nxt   = cnt_r;
    quot_nxt  = quot_r;
    valid_nxt = 1'b0;
    temp_nxt  = temp_r;
    oflag_nxt = oflag_r;
    unique case (state_r)
      ntci_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          rem_nxt  = q_job.num;
          den_nxt  = q_job.den;
          base_nxt = q_job.base;
          flag_nxt = q_job.flag;
          cnt_nxt  = CntW'(ntci_pkg::QuotW - 1);
          quot_nxt = '0;
        end
      end
      ntci_pkg::BK_DIV: begin
        if (fits) rem_nxt = rem_r - trial;
        quot_nxt = {quot_r[ntci_pkg::QuotW-2:0], fits};
        cnt_nxt  = cnt_r - CntW'(1);
        if (cnt_r == '0) begin
          valid_nxt = 1'b1;
          temp_nxt  = base_r + ntci_pkg::TempW'(quot_nxt);
          oflag_nxt = flag_r;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntci_pkg::BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    base_r  <= base_nxt;
    flag_r  <= flag_nxt;
    cnt_r   <= cnt_nxt;
    quot_r  <= quot_nxt;
    temp_r  <= temp_nxt;
    oflag_r <= oflag_nxt;
  end

  assign out_valid         = valid_r;
  assign out_temperature_c = signed'(temp_r);
  assign out_range_flag    = oflag_r;

endmodule

`default_nettype wire

// ===== design/ntc_table_interpolation_unit.sv =====
// NTC table interpolation unit: converter reading in, whole-degree temperature out.
// A reading passes the front-end register and the job queue before the divider takes it.
// The divider loads a job, then takes three quotient steps before it can load the next.
// The front end holds one reading and the queue two jobs, so short bursts are absorbed.
// Synchronous active-low reset empties the front end, the queue and the divider.
// Depends on ntci_pkg, ntci_front, ntci_fifo and ntci_back.
`default_nettype none

module ntc_table_interpolation_unit #(
  parameter int TABLE_POINTS = ntci_pkg::TablePoints
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ntci_pkg::AdcW-1:0]     in_adc_reading,
  output logic                               out_valid,
  output logic signed [ntci_pkg::TempW-1:0]  out_temperature_c,
  output logic [ntci_pkg::FlagW-1:0]         out_range_flag
);

  ntci_pkg::job_t push_job, pop_job;
  logic           q_push, q_pop, q_full, q_empty;

  ntci_front #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_adc_reading (in_adc_reading),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  ntci_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_job),
    .pop     (q_pop),
    .rd_data (pop_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  ntci_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_job             (pop_job),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_temperature_c (out_temperature_c),
    .out_range_flag    (out_range_flag)
  );

  // The divider returns to idle to load each job, so strobes are never adjacent.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in consecutive cycles");

  a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_range_flag == ntci_pkg::RANGE_IN ||
                   out_range_flag == ntci_pkg::RANGE_LOW ||
                   out_range_flag == ntci_pkg::RANGE_HIGH))
    else $error("range flag carries an unused code");

  a_low_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_flag == ntci_pkg::RANGE_LOW) |->
      (out_temperature_c == ntci_pkg::TempW'(ntci_pkg::BaseTemp)))
    else $error("low clamp gives a temperature other than the first point");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !(q_push && !q_pop))
    else $error("job written into a full queue");

endmodule

`default_nettype wire

// ===== bench/tb_ntc_table_interpolation_unit.sv =====
// Testbench for ntc_table_interpolation_unit. It predicts each temperature from its own copy of
// the calibration table, then checks every strobed result in order against that prediction.
// Depends on ntci_pkg and the unit's RTL only.
module tb_ntc_table_interpolation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClockPeriod  = 20;
  localparam int ResetCycles  = 12;
  localparam int MaxGap       = 6;
  localparam int DrainCycles  = 10;
  localparam int CycleLimit   = 200000;
  localparam int NumCalPoints = 13;
  localparam int ColdestC     = -20;
  localparam int DegreesStep  = 5;

  // Converter values at -20 C, -15 C, ... +40 C.
  localparam int CalPoints [NumCalPoints] = '{
    75, 100, 131, 169, 214, 265, 322, 384, 447, 512, 574, 633, 687
  };

  typedef struct {
    ntci_pkg::temp_t  temp;
    ntci_pkg::range_t flag;
  } reading_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  ntci_pkg::adc_t in_adc_reading;
  logic        out_valid;
  logic signed [ntci_pkg::TempW-1:0] out_temperature_c;
  logic [ntci_pkg::FlagW-1:0]        out_range_flag;

  reading_result_t pending_results[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  idle_gaps = 1'b1;

  ntc_table_interpolation_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_adc_reading    (in_adc_reading),
    .out_valid         (out_valid),
    .out_temperature_c (out_temperature_c),
    .out_range_flag    (out_range_flag)
  );

  initial clk = 1'b0;
  always #(ClockPeriod / 2) clk = ~clk;

  function automatic reading_result_t linearize_reading(ntci_pkg::adc_t reading);
    reading_result_t res;
    int seg;
    int lo;
    int hi;
    int deg;
    res.flag = ntci_pkg::RANGE_IN;
    seg = 1;
    if (int'(reading) < CalPoints[0]) begin
      deg = ColdestC;
      res.flag = ntci_pkg::RANGE_LOW;
    end else if (int'(reading) > CalPoints[NumCalPoints-1]) begin
      deg = ColdestC + DegreesStep * (NumCalPoints - 1);
      res.flag = ntci_pkg::RANGE_HIGH;
    end else if (int'(reading) == CalPoints[0]) begin
      deg = ColdestC;
    end else begin
      // Find the first point that is not below the reading; the division truncates.
      while (seg < NumCalPoints - 1 && int'(reading) > CalPoints[seg]) seg++;
      lo = CalPoints[seg-1];
      hi = CalPoints[seg];
      deg = ColdestC + DegreesStep * (seg - 1) +
            (DegreesStep * (int'(reading) - lo)) / (hi - lo);
    end
    res.temp = ntci_pkg::temp_t'(deg);
    return res;
  endfunction

  // Entered just after a falling edge; returns just after the falling edge following acceptance.
  task automatic send_reading(input ntci_pkg::adc_t reading);
    int gap;
    gap = idle_gaps ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_adc_reading <= reading;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(linearize_reading(reading));
    @(negedge clk);
  endtask

  function automatic ntci_pkg::adc_t pick_reading();
    int kind;
    int val;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      val = $urandom_range(CalPoints[0], CalPoints[NumCalPoints-1]);
    end else if (kind < 8) begin
      // Readings close to a table point, where segment selection matters most.
      val = CalPoints[$urandom_range(0, NumCalPoints - 1)] + $urandom_range(0, 4) - 2;
    end else begin
      val = $urandom_range(0, 1023);
    end
    return ntci_pkg::adc_t'(val);
  endfunction

  task automatic test_range_clamps();
    send_reading(10'd0);
    send_reading(10'd1023);
    send_reading(10'd74);
    send_reading(10'd75);
    send_reading(10'd76);
    send_reading(10'd686);
    send_reading(10'd687);
    send_reading(10'd688);
    send_reading(10'h155);
    send_reading(10'h2AA);
  endtask

  task automatic test_table_points();
    for (int k = 1; k < NumCalPoints - 1; k++) send_reading(ntci_pkg::adc_t'(CalPoints[k]));
  endtask

  task automatic test_back_to_back(input int count);
    idle_gaps = 1'b0;
    repeat (count) send_reading(pick_reading());
    idle_gaps = 1'b1;
  endtask

  task automatic test_random_readings(input int count);
    repeat (count) send_reading(pick_reading());
  endtask

  always @(posedge clk) begin
    reading_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction pending: temperature %0d flag %0d",
                 $time, out_temperature_c, out_range_flag);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_temperature_c !== exp_res.temp) begin
          $display("%0t: temperature mismatch: expected %0d actual %0d",
                   $time, $signed(exp_res.temp), out_temperature_c);
          mismatch_count++;
        end
        if (out_range_flag !== exp_res.flag) begin
          $display("%0t: range flag mismatch: expected %0d actual %0d",
                   $time, exp_res.flag, out_range_flag);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("ntc_table_interpolation_unit verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_adc_reading = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_range_clamps();
    test_table_points();
    test_back_to_back(250);
    test_random_readings(680);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0) mismatch_count++;

    if (mismatch_count == 0) begin
      $display("ntc_table_interpolation_unit verification clean");
    end else begin
      $display("ntc_table_interpolation_unit verification failed");
    end
    $finish;
  end

endmodule
